FILE: rtl/slbc_pkg.sv
// Shared types and constants for the status LED blink-code controller.
`default_nettype none

package slbc_pkg;

	// Action codes carried in a request
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_MODE = 2'd1;
	localparam logic [1:0] ACT_CODE = 2'd2;

	// Mode codes
	localparam logic [2:0] MODE_OFF       = 3'd0;
	localparam logic [2:0] MODE_IDLE      = 3'd1;
	localparam logic [2:0] MODE_WORKING   = 3'd2;
	localparam logic [2:0] MODE_RECEIVING = 3'd3;
	localparam logic [2:0] MODE_REBOOTING = 3'd4;
	localparam logic [2:0] MODE_ERROR     = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] REG_TICK_PERIOD = 3'd0;
	localparam logic [2:0] REG_SLOW_HALF   = 3'd1;
	localparam logic [2:0] REG_FAST_HALF   = 3'd2;
	localparam logic [2:0] REG_VFAST_HALF  = 3'd3;
	localparam logic [2:0] REG_ERR_TOGGLE  = 3'd4;
	localparam logic [2:0] REG_ERR_PAUSE   = 3'd5;

	// Configuration reset values
	localparam logic [9:0]  TICK_PERIOD_RST = 10'd50;
	localparam logic [13:0] SLOW_HALF_RST   = 14'd500;
	localparam logic [13:0] FAST_HALF_RST   = 14'd125;
	localparam logic [13:0] VFAST_HALF_RST  = 14'd50;
	localparam logic [13:0] ERR_TOGGLE_RST  = 14'd150;
	localparam logic [15:0] ERR_PAUSE_RST   = 16'd2000;

	localparam logic [6:0]  CODE_MAX      = 7'd127;
	localparam logic [7:0]  TOGGLE_MAX    = 8'd255;
	localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] new_mode;
		logic [7:0] new_error_code;
	} slbc_req_t;

	typedef struct packed {
		logic       led_on;
		logic [2:0] current_mode;
		logic [6:0] current_error_code;
	} slbc_rsp_t;

	typedef struct packed {
		logic [9:0]  tick_period_ms;
		logic [13:0] slow_half_ms;
		logic [13:0] fast_half_ms;
		logic [13:0] very_fast_half_ms;
		logic [13:0] error_toggle_ms;
		logic [15:0] pause_gap_ms;
	} slbc_cfg_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [6:0]  error_code;
		logic        led;
		logic [7:0]  toggle_count;
		logic        in_pause;
		logic [15:0] elapsed_ms;
	} slbc_state_t;

endpackage

`default_nettype wire

FILE: rtl/status_led_blink_code_controller.sv
// Top level: input register, blink engine, config registers and result register.
// A request in the input register moves to the result register, out_valid high, when not stalled.
// Throughput: one request per cycle unless stalled; state update is a combinational add and compare.
// Stall on the result side holds the result register and backs up into the input stage.
// Reset (arst_n low, asynchronous): mode off, LED dark, counters and error code zero,
// configuration registers back to their default periods; no clearing pass.
`default_nettype none

module status_led_blink_code_controller (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire slbc_pkg::slbc_req_t            in_req,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output slbc_pkg::slbc_rsp_t                 out_rsp,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [slbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [slbc_pkg::CFG_DATA_W-1:0] cfg_data
);

	slbc_pkg::slbc_cfg_t   cfg;
	slbc_pkg::slbc_req_t   req_s1;
	logic                  valid_s1;
	slbc_pkg::slbc_state_t st;
	slbc_pkg::slbc_state_t st_nxt;
	slbc_pkg::slbc_rsp_t   rsp_q;
	logic                  rsp_valid_q;
	logic                  advance;
	logic                  fire;

	// Pipeline moves when the result register is free or being drained
	assign advance = !rsp_valid_q || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	slbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_req;
		end
	end

	slbc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.cfg    (cfg),
		.st     (st),
		.st_nxt (st_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.led_on             <= st_nxt.led;
			rsp_q.current_mode       <= st_nxt.mode;
			rsp_q.current_error_code <= st_nxt.error_code;
		end
	end

	assign out_valid = rsp_valid_q;
	assign out_rsp = rsp_q;

	// Checks on the engine state
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		st.mode == slbc_pkg::MODE_OFF |-> !st.led)
		else $error("LED lit in off mode");

	a_rx_lit: assert property (@(posedge clk) disable iff (!arst_n)
		st.mode == slbc_pkg::MODE_RECEIVING |-> st.led)
		else $error("LED dark in receiving mode");

	a_pause_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(st.mode == slbc_pkg::MODE_ERROR && st.in_pause) |-> !st.led)
		else $error("LED lit during error pause");

	a_mode_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_rsp.current_mode <= slbc_pkg::MODE_ERROR)
		else $error("undefined mode reported");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(st))
		else $error("state changed without a request");

endmodule

`default_nettype wire

FILE: rtl/slbc_cfg.sv
// Configuration register file for the blink-code controller.
`default_nettype none

module slbc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [slbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [slbc_pkg::CFG_DATA_W-1:0] cfg_data,
	output slbc_pkg::slbc_cfg_t                 cfg
);

	slbc_pkg::slbc_cfg_t cfg_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register writes, masked to each register's width; unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period_ms    <= slbc_pkg::TICK_PERIOD_RST;
			cfg_q.slow_half_ms      <= slbc_pkg::SLOW_HALF_RST;
			cfg_q.fast_half_ms      <= slbc_pkg::FAST_HALF_RST;
			cfg_q.very_fast_half_ms <= slbc_pkg::VFAST_HALF_RST;
			cfg_q.error_toggle_ms   <= slbc_pkg::ERR_TOGGLE_RST;
			cfg_q.pause_gap_ms      <= slbc_pkg::ERR_PAUSE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				slbc_pkg::REG_TICK_PERIOD: cfg_q.tick_period_ms    <= cfg_data[9:0];
				slbc_pkg::REG_SLOW_HALF:   cfg_q.slow_half_ms      <= cfg_data[13:0];
				slbc_pkg::REG_FAST_HALF:   cfg_q.fast_half_ms      <= cfg_data[13:0];
				slbc_pkg::REG_VFAST_HALF:  cfg_q.very_fast_half_ms <= cfg_data[13:0];
				slbc_pkg::REG_ERR_TOGGLE:  cfg_q.error_toggle_ms   <= cfg_data[13:0];
				slbc_pkg::REG_ERR_PAUSE:   cfg_q.pause_gap_ms      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/slbc_core.sv
// Blink engine: mode, error code, LED and timing state with its update logic.
`default_nettype none

module slbc_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire slbc_pkg::slbc_req_t  req,
	input  wire slbc_pkg::slbc_cfg_t  cfg,
	output slbc_pkg::slbc_state_t     st,
	output slbc_pkg::slbc_state_t     st_nxt
);

	slbc_pkg::slbc_state_t st_q;

	// Mode entry; same mode or an undefined code leaves everything alone
	function automatic slbc_pkg::slbc_state_t enter_mode(
		input slbc_pkg::slbc_state_t s, input logic [2:0] m);
		slbc_pkg::slbc_state_t r;
		r = s;
		if (m <= slbc_pkg::MODE_ERROR && m != s.mode) begin
			r.mode = m;
			r.led = 1'b0;
			r.elapsed_ms = '0;
			if (m == slbc_pkg::MODE_RECEIVING) begin
				r.led = 1'b1;
			end else if (m == slbc_pkg::MODE_ERROR) begin
				r.toggle_count = '0;
				r.in_pause = 1'b0;
				r.led = 1'b1;
			end
		end
		return r;
	endfunction

	logic [16:0] sum;
	logic [15:0] adv;
	logic [13:0] half;
	logic        blinking;
	logic [7:0]  tc_inc;
	slbc_pkg::slbc_state_t tmp;

	// Saturating time advance
	assign sum = {1'b0, st_q.elapsed_ms} + {7'd0, cfg.tick_period_ms};
	assign adv = sum[16] ? slbc_pkg::ELAPSED_MAX : sum[15:0];
	assign tc_inc = (st_q.toggle_count != slbc_pkg::TOGGLE_MAX) ?
		st_q.toggle_count + 8'd1 : st_q.toggle_count;

	// Half period for the blinking modes
	always_comb begin
		half = cfg.slow_half_ms;
		blinking = 1'b0;
		case (st_q.mode)
			slbc_pkg::MODE_IDLE: begin
				half = cfg.slow_half_ms;
				blinking = 1'b1;
			end
			slbc_pkg::MODE_WORKING: begin
				half = cfg.fast_half_ms;
				blinking = 1'b1;
			end
			slbc_pkg::MODE_REBOOTING: begin
				half = cfg.very_fast_half_ms;
				blinking = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Next state for the request at hand
	always_comb begin
		tmp = st_q;
		st_nxt = st_q;
		case (req.action)
			slbc_pkg::ACT_TICK: begin
				if (st_q.mode == slbc_pkg::MODE_ERROR) begin
					st_nxt.elapsed_ms = adv;
					if (!st_q.in_pause) begin
						if (adv >= {2'b00, cfg.error_toggle_ms}) begin
							st_nxt.elapsed_ms = '0;
							st_nxt.led = ~st_q.led;
							st_nxt.toggle_count = tc_inc;
							// group done after two toggles per code unit
							if (tc_inc >= {st_q.error_code, 1'b0}) begin
								st_nxt.led = 1'b0;
								st_nxt.in_pause = 1'b1;
							end
						end
					end else if (adv >= cfg.pause_gap_ms) begin
						st_nxt.toggle_count = '0;
						st_nxt.in_pause = 1'b0;
						st_nxt.elapsed_ms = '0;
						st_nxt.led = 1'b1;
					end
				end else if (blinking) begin
					st_nxt.elapsed_ms = adv;
					if (adv >= {2'b00, half}) begin
						st_nxt.elapsed_ms = '0;
						st_nxt.led = ~st_q.led;
					end
				end
			end
			slbc_pkg::ACT_MODE: begin
				st_nxt = enter_mode(st_q, req.new_mode);
			end
			slbc_pkg::ACT_CODE: begin
				tmp.error_code = req.new_error_code[7] ? slbc_pkg::CODE_MAX :
					req.new_error_code[6:0];
				st_nxt = enter_mode(tmp, slbc_pkg::MODE_ERROR);
			end
			default: begin
			end
		endcase
	end

	// State update when a request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	assign st = st_q;

endmodule

`default_nettype wire

FILE: test/status_led_blink_code_controller_tb.sv
// Self-checking testbench for the status LED blink-code controller.
`default_nettype none

module status_led_blink_code_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Codes that the package leaves unnamed: an action that does nothing, undefined modes
	localparam logic [1:0] ACT_NONE   = 2'd3;
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_stall;
	slbc_pkg::slbc_req_t                  in_req;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	slbc_pkg::slbc_rsp_t                  out_rsp;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [slbc_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [slbc_pkg::CFG_DATA_W-1:0]      cfg_data;

	// Predicted block state and periods
	slbc_pkg::slbc_cfg_t   period_cfg;
	slbc_pkg::slbc_state_t led_st;
	slbc_pkg::slbc_rsp_t   pending_status_q[$];

	int  fail_count = 0;
	int  req_count = 0;
	int  reg_writes = 0;
	int  pulse_groups = 0;
	int  stall_run = 0;
	bit  tx_gap_en = 1'b0;
	bit  rx_stall_en = 1'b0;

	status_led_blink_code_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_rsp(out_rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Predictor: mode entry
	function automatic void apply_mode(logic [2:0] m);
		if (m > slbc_pkg::MODE_ERROR || m == led_st.mode)
			return;
		led_st.mode = m;
		led_st.led = 1'b0;
		led_st.elapsed_ms = '0;
		if (m == slbc_pkg::MODE_RECEIVING) begin
			led_st.led = 1'b1;
		end else if (m == slbc_pkg::MODE_ERROR) begin
			led_st.toggle_count = '0;
			led_st.in_pause = 1'b0;
			led_st.led = 1'b1;
		end
	endfunction

	// Predictor: one tick worth of milliseconds, saturating
	function automatic void add_tick_time();
		int sum;
		sum = int'(led_st.elapsed_ms) + int'(period_cfg.tick_period_ms);
		led_st.elapsed_ms = (sum > int'(slbc_pkg::ELAPSED_MAX)) ? slbc_pkg::ELAPSED_MAX :
			sum[15:0];
	endfunction

	// Predictor: next LED status for one request
	function automatic slbc_pkg::slbc_rsp_t blink_step(slbc_pkg::slbc_req_t r);
		logic [15:0]         half;
		bit                  blinks;
		slbc_pkg::slbc_rsp_t rsp;
		half = '0;
		blinks = 1'b1;
		case (r.action)
			slbc_pkg::ACT_TICK: begin
				if (led_st.mode == slbc_pkg::MODE_ERROR) begin
					add_tick_time();
					if (!led_st.in_pause) begin
						if (led_st.elapsed_ms >= period_cfg.error_toggle_ms) begin
							led_st.elapsed_ms = '0;
							led_st.led = ~led_st.led;
							if (led_st.toggle_count < slbc_pkg::TOGGLE_MAX)
								led_st.toggle_count++;
							if (int'(led_st.toggle_count) >= 2 * int'(led_st.error_code)) begin
								led_st.led = 1'b0;
								led_st.in_pause = 1'b1;
								pulse_groups++;
							end
						end
					end else if (led_st.elapsed_ms >= period_cfg.pause_gap_ms) begin
						led_st.toggle_count = '0;
						led_st.in_pause = 1'b0;
						led_st.elapsed_ms = '0;
						led_st.led = 1'b1;
					end
				end else begin
					case (led_st.mode)
						slbc_pkg::MODE_IDLE:      half = 16'(period_cfg.slow_half_ms);
						slbc_pkg::MODE_WORKING:   half = 16'(period_cfg.fast_half_ms);
						slbc_pkg::MODE_REBOOTING: half = 16'(period_cfg.very_fast_half_ms);
						default:                  blinks = 1'b0;
					endcase
					if (blinks) begin
						add_tick_time();
						if (led_st.elapsed_ms >= half) begin
							led_st.elapsed_ms = '0;
							led_st.led = ~led_st.led;
						end
					end
				end
			end
			slbc_pkg::ACT_MODE: apply_mode(r.new_mode);
			slbc_pkg::ACT_CODE: begin
				led_st.error_code = (r.new_error_code > 8'(slbc_pkg::CODE_MAX)) ?
					slbc_pkg::CODE_MAX : r.new_error_code[6:0];
				apply_mode(slbc_pkg::MODE_ERROR);
			end
			default: ;
		endcase
		rsp.led_on = led_st.led;
		rsp.current_mode = led_st.mode;
		rsp.current_error_code = led_st.error_code;
		return rsp;
	endfunction

	function automatic slbc_pkg::slbc_req_t mk_req(logic [1:0] a, logic [2:0] m,
			logic [7:0] c);
		slbc_pkg::slbc_req_t r;
		r.action = a;
		r.new_mode = m;
		r.new_error_code = c;
		return r;
	endfunction

	// Sender gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		if (!tx_gap_en)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random request: mostly ticks between mode and code changes, some noise
	function automatic slbc_pkg::slbc_req_t rand_req();
		int                  roll;
		slbc_pkg::slbc_req_t r;
		roll = $urandom_range(0, 99);
		r = mk_req(slbc_pkg::ACT_TICK, 3'($urandom), 8'($urandom));
		if (roll >= 70 && roll < 84) begin
			r.action = slbc_pkg::ACT_MODE;
			r.new_mode = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7)) :
				3'($urandom_range(0, 5));
		end else if (roll >= 84 && roll < 95) begin
			r.action = slbc_pkg::ACT_CODE;
			roll = $urandom_range(0, 9);
			if (roll < 7)
				r.new_error_code = 8'($urandom_range(0, 6));
			else if (roll < 9)
				r.new_error_code = 8'($urandom_range(0, 255));
			else
				r.new_error_code = 8'($urandom_range(128, 255));
		end else if (roll >= 95) begin
			r.action = ACT_NONE;
		end
		return r;
	endfunction

	// Send one request, with an optional gap ahead of it
	task automatic send_request(slbc_pkg::slbc_req_t r);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do @(posedge clk); while (in_stall);
		pending_status_q.push_back(blink_step(r));
		req_count++;
	endtask

	// Hold off the sender until every predicted status has come back
	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_status_q.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(logic [slbc_pkg::CFG_IDX_W-1:0] idx,
			logic [slbc_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			slbc_pkg::REG_TICK_PERIOD: period_cfg.tick_period_ms = d[9:0];
			slbc_pkg::REG_SLOW_HALF:   period_cfg.slow_half_ms = d[13:0];
			slbc_pkg::REG_FAST_HALF:   period_cfg.fast_half_ms = d[13:0];
			slbc_pkg::REG_VFAST_HALF:  period_cfg.very_fast_half_ms = d[13:0];
			slbc_pkg::REG_ERR_TOGGLE:  period_cfg.error_toggle_ms = d[13:0];
			slbc_pkg::REG_ERR_PAUSE:   period_cfg.pause_gap_ms = d;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram all periods once the block has gone idle
	task automatic load_periods(logic [15:0] tick, logic [15:0] slow, logic [15:0] fast,
			logic [15:0] vfast, logic [15:0] toggle, logic [15:0] pause);
		wait_all_results();
		cfg_write(slbc_pkg::REG_TICK_PERIOD, tick);
		cfg_write(slbc_pkg::REG_SLOW_HALF, slow);
		cfg_write(slbc_pkg::REG_FAST_HALF, fast);
		cfg_write(slbc_pkg::REG_VFAST_HALF, vfast);
		cfg_write(slbc_pkg::REG_ERR_TOGGLE, toggle);
		cfg_write(slbc_pkg::REG_ERR_PAUSE, pause);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_request(mk_req(slbc_pkg::ACT_TICK, 3'($urandom), 8'($urandom)));
	endtask

	// Out of reset: off mode stays dark; unused action and undefined modes do nothing
	task automatic test_reset_and_ignored();
		tx_gap_en = 1'b1;
		rx_stall_en = 1'b1;
		send_request(mk_req(slbc_pkg::ACT_TICK, slbc_pkg::MODE_OFF, 8'h00));
		send_request(mk_req(ACT_NONE, MODE_RSVD7, 8'hFF));
		send_request(mk_req(slbc_pkg::ACT_MODE, MODE_RSVD6, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_MODE, MODE_RSVD7, 8'hFF));
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_OFF, 8'h55));
		send_request(mk_req(slbc_pkg::ACT_TICK, MODE_RSVD7, 8'hAA));
	endtask

	// Solid and blinking modes with short periods, including repeated mode requests
	task automatic test_steady_blink();
		load_periods(16'd1, 16'd3, 16'd2, 16'd1, 16'd1, 16'd2);
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_IDLE, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_TICK, slbc_pkg::MODE_OFF, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_IDLE, 8'h00));
		send_ticks(5);
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_WORKING, 8'h00));
		send_ticks(4);
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_REBOOTING, 8'h00));
		send_ticks(2);
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_RECEIVING, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_RECEIVING, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_TICK, slbc_pkg::MODE_OFF, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_OFF, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_TICK, slbc_pkg::MODE_OFF, 8'h00));
	endtask

	// Error pulses: zero code, saturating code, code change without restart
	task automatic test_error_pulses();
		send_request(mk_req(slbc_pkg::ACT_CODE, slbc_pkg::MODE_OFF, 8'd0));
		send_ticks(3);
		send_request(mk_req(slbc_pkg::ACT_CODE, slbc_pkg::MODE_OFF, 8'd200));
		send_request(mk_req(slbc_pkg::ACT_CODE, slbc_pkg::MODE_OFF, 8'd255));
		send_request(mk_req(slbc_pkg::ACT_CODE, slbc_pkg::MODE_OFF, 8'd1));
		send_ticks(5);
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_ERROR, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_IDLE, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_ERROR, 8'h00));
		send_ticks(4);
	endtask

	// All periods zero: every tick toggles in working mode, and each error tick steps the pulse or pause at once
	task automatic test_zero_periods();
		load_periods(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_WORKING, 8'h00));
		send_ticks(3);
		send_request(mk_req(slbc_pkg::ACT_CODE, slbc_pkg::MODE_OFF, 8'd2));
		send_ticks(7);
	endtask

	// Largest tick and pause: the pause count runs into the clamp and still ends
	task automatic test_elapsed_saturation();
		load_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(mk_req(slbc_pkg::ACT_MODE, slbc_pkg::MODE_OFF, 8'h00));
		send_request(mk_req(slbc_pkg::ACT_CODE, slbc_pkg::MODE_OFF, 8'd0));
		send_ticks(85);
	endtask

	task automatic run_random_phase(int n, bit gaps, bit stalls);
		tx_gap_en = gaps;
		rx_stall_en = stalls;
		repeat (n) begin
			send_request(rand_req());
			if ($urandom_range(0, 49) == 0)
				wait_all_results();
		end
	endtask

	task automatic test_random_traffic();
		load_periods(16'(slbc_pkg::TICK_PERIOD_RST), 16'(slbc_pkg::SLOW_HALF_RST),
			16'(slbc_pkg::FAST_HALF_RST), 16'(slbc_pkg::VFAST_HALF_RST),
			16'(slbc_pkg::ERR_TOGGLE_RST), slbc_pkg::ERR_PAUSE_RST);
		run_random_phase(80, 1'b1, 1'b1);
		load_periods(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		run_random_phase(80, 1'b0, 1'b0);
		load_periods(16'($urandom_range(1, 100)), 16'($urandom_range(1, 500)),
			16'($urandom_range(1, 500)), 16'($urandom_range(1, 500)),
			16'($urandom_range(1, 300)), 16'($urandom_range(1, 2000)));
		run_random_phase(80, 1'b1, 1'b0);
		load_periods(16'd1000, 16'd10000, 16'd10000, 16'd10000, 16'd10000, 16'd60000);
		run_random_phase(80, 1'b0, 1'b1);
		load_periods(16'($urandom_range(1, 60)), 16'($urandom_range(1, 300)),
			16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
			16'($urandom_range(1, 200)), 16'($urandom_range(1, 1000)));
		run_random_phase(80, 1'b1, 1'b1);
		wait_all_results();
	endtask

	// Receiver stalls: runs of ready and stalled cycles, occasionally long
	always @(negedge clk) begin
		if (stall_run <= 0) begin
			if (!rx_stall_en || $urandom_range(0, 99) >= 30) begin
				out_stall <= 1'b0;
				stall_run = $urandom_range(1, 4);
			end else begin
				out_stall <= 1'b1;
				stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
					$urandom_range(1, 3);
			end
		end
		stall_run--;
	end

	// Compare each delivered status with the oldest prediction
	always @(posedge clk) begin
		slbc_pkg::slbc_rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status_q.size() == 0) begin
				$error("status delivered with no request outstanding: %p", out_rsp);
				fail_count++;
			end else begin
				want = pending_status_q.pop_front();
				if (out_rsp.led_on !== want.led_on) begin
					$error("led_on: expected %0d, got %0d", want.led_on, out_rsp.led_on);
					fail_count++;
				end
				if (out_rsp.current_mode !== want.current_mode) begin
					$error("current_mode: expected %0d, got %0d", want.current_mode,
						out_rsp.current_mode);
					fail_count++;
				end
				if (out_rsp.current_error_code !== want.current_error_code) begin
					$error("current_error_code: expected %0d, got %0d",
						want.current_error_code, out_rsp.current_error_code);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		period_cfg.tick_period_ms = slbc_pkg::TICK_PERIOD_RST;
		period_cfg.slow_half_ms = slbc_pkg::SLOW_HALF_RST;
		period_cfg.fast_half_ms = slbc_pkg::FAST_HALF_RST;
		period_cfg.very_fast_half_ms = slbc_pkg::VFAST_HALF_RST;
		period_cfg.error_toggle_ms = slbc_pkg::ERR_TOGGLE_RST;
		period_cfg.pause_gap_ms = slbc_pkg::ERR_PAUSE_RST;
		led_st = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_and_ignored();
		test_steady_blink();
		test_error_pulses();
		test_zero_periods();
		test_elapsed_saturation();
		test_random_traffic();

		// Let anything stray surface after the last status
		repeat (8) @(posedge clk);
		$display("Ran %0d requests across %0d register writes; %0d error pulse groups completed.",
			req_count, reg_writes, pulse_groups);
		$display("Sender gaps and receiver stalls were both switched on and off by phase.");
		if (fail_count == 0 && pending_status_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
